### hw/rtl/byte_ring_buffer_with_search_top_defines.svh
// Assertion macros shared by the byte ring buffer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef BYTE_RING_BUFFER_WITH_SEARCH_TOP_DEFINES_SVH
`define BYTE_RING_BUFFER_WITH_SEARCH_TOP_DEFINES_SVH

// A property that holds at every clock edge outside reset.
`define BRBS_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define BRBS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define BRBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/brbs_pkg.sv
// Types and constants of the byte ring buffer with search.
// Depends on nothing; used by byte_ring_buffer_with_search_top.
`timescale 1ns / 1ps

package brbs_pkg;

   localparam int DEFAULT_DEPTH = 1024;
   localparam int BYTE_W        = 8;
   localparam int COUNT_W       = 10;
   localparam int OP_W          = 3;
   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = 40;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 3'd0,
      OP_PUSH   = 3'd1,
      OP_POP    = 3'd2,
      OP_PEEK   = 3'd3,
      OP_FIND   = 3'd4,
      OP_RESET  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_FIND
   } state_type;

endpackage

### hw/rtl/byte_ring_buffer_with_search_top.sv
// Byte ring buffer with search: the whole block in one module around one byte memory.
// Depends on brbs_pkg and byte_ring_buffer_with_search_top_defines.svh.
`timescale 1ns / 1ps
`include "byte_ring_buffer_with_search_top_defines.svh"

// A ring of DEPTH byte slots holding up to DEPTH-1 bytes, kept in one synchronous memory
// with a registered read. Append, push front, reset pointers, unknown opcodes and a failed
// append, push front, pop or peek answer straight from the idle state, so a stream of them
// runs at one byte per clock while the response side is ready. A pop or peek that succeeds
// passes through the read state, because the byte comes out of the memory in the cycle
// after its address. Find reads one held byte per cycle from the head until the first
// match or the last held byte, and answers at once on an empty buffer. A request is
// taken only while no earlier one is still in progress and no finished result waits,
// except that a result transferred in a cycle frees the input in that same cycle. Nothing
// is taken during reset. The memory needs no clearing after reset, since only written
// slots are ever read.
module byte_ring_buffer_with_search_top #(
   parameter int DEPTH = brbs_pkg::DEFAULT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // data_byte [7:0], position [17:8], zero [23:18]
   input  logic [brbs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // opcode [2:0]
   input  logic [brbs_pkg::OP_W-1:0]         req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_data [7:0], found_offset [17:8], fill_count [27:18], free_count [37:28],
   // zero [39:38]
   output logic [brbs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // success [0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int PW    = $clog2(DEPTH);
   localparam int CMP_W = (PW > brbs_pkg::COUNT_W) ? PW : brbs_pkg::COUNT_W;
   localparam logic [PW-1:0] MAX_FILL = PW'(DEPTH - 1);
   localparam logic [PW:0]   DEPTH_X  = (PW+1)'(DEPTH);

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] a);
      return (a == MAX_FILL) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] a);
      return (a == '0) ? MAX_FILL : a - 1'b1;
   endfunction

   function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                              input logic [PW-1:0] b);
      logic [PW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_X) begin
         s = s - DEPTH_X;
      end
      return s[PW-1:0];
   endfunction

   brbs_pkg::state_type  state_ff, state_in;
   logic [PW-1:0]        head_ff, head_in;
   logic [PW-1:0]        tail_ff, tail_in;
   logic [PW-1:0]        fill_ff, fill_in;
   logic [PW-1:0]        idx_ff, idx_in;
   logic [PW-1:0]        scan_ff, scan_in;
   brbs_pkg::byte_type   key_ff, key_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   brbs_pkg::byte_type   rsp_rd_ff, rsp_rd_in;
   brbs_pkg::count_type  rsp_found_ff, rsp_found_in;
   brbs_pkg::count_type  rsp_fill_ff, rsp_fill_in;
   brbs_pkg::count_type  rsp_free_ff, rsp_free_in;
   logic                 rsp_last_ff, rsp_last_in;

   brbs_pkg::byte_type   mem [DEPTH];
   brbs_pkg::byte_type   mem_q_ff;
   logic                 wr_en, rd_en;
   logic [PW-1:0]        wr_addr, rd_addr;
   brbs_pkg::byte_type   wr_data;

   logic                 accept;
   brbs_pkg::op_type     req_op;
   brbs_pkg::byte_type   req_byte;
   brbs_pkg::count_type  req_pos;
   logic [PW-1:0]        pos_idx;
   logic [PW:0]          ptr_fill;

   assign req_op   = brbs_pkg::op_type'(req_tuser);
   assign req_byte = req_tdata[7:0];
   assign req_pos  = req_tdata[17:8];
   assign pos_idx  = PW'(req_pos);
   assign accept   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_free_ff, rsp_fill_ff, rsp_found_ff, rsp_rd_ff};
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign ptr_fill = (tail_ff >= head_ff) ? ({1'b0, tail_ff} - {1'b0, head_ff})
                                          : ({1'b0, tail_ff} + DEPTH_X - {1'b0, head_ff});

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      scan_in      = scan_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_found_in = rsp_found_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_free_in  = rsp_free_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_ff;
      wr_data      = req_byte;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      req_tready   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         brbs_pkg::ST_IDLE: begin
            req_tready = !reset && (!rsp_valid_ff || rsp_tready);
            if (accept) begin
               rsp_last_in  = req_tlast;
               rsp_ok_in    = 1'b0;
               rsp_rd_in    = '0;
               rsp_found_in = '0;
               case (req_op)
                  brbs_pkg::OP_APPEND: begin
                     if (fill_ff != MAX_FILL) begin
                        wr_en     = 1'b1;
                        wr_addr   = tail_ff;
                        tail_in   = wrap_inc(tail_ff);
                        fill_in   = fill_ff + 1'b1;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  brbs_pkg::OP_PUSH: begin
                     if (fill_ff != MAX_FILL) begin
                        wr_en     = 1'b1;
                        wr_addr   = wrap_dec(head_ff);
                        head_in   = wrap_dec(head_ff);
                        fill_in   = fill_ff + 1'b1;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  brbs_pkg::OP_POP: begin
                     if (fill_ff != '0) begin
                        rd_en     = 1'b1;
                        rd_addr   = head_ff;
                        head_in   = wrap_inc(head_ff);
                        fill_in   = fill_ff - 1'b1;
                        rsp_ok_in = 1'b1;
                        state_in  = brbs_pkg::ST_READ;
                     end
                  end
                  brbs_pkg::OP_PEEK: begin
                     if (CMP_W'(req_pos) < CMP_W'(fill_ff)) begin
                        rd_en     = 1'b1;
                        rd_addr   = wrap_add(head_ff, pos_idx);
                        rsp_ok_in = 1'b1;
                        state_in  = brbs_pkg::ST_READ;
                     end
                  end
                  brbs_pkg::OP_FIND: begin
                     if (fill_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        scan_in  = head_ff;
                        idx_in   = '0;
                        key_in   = req_byte;
                        state_in = brbs_pkg::ST_FIND;
                     end
                  end
                  brbs_pkg::OP_RESET: begin
                     head_in   = '0;
                     tail_in   = '0;
                     fill_in   = '0;
                     rsp_ok_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
               rsp_fill_in  = brbs_pkg::count_type'(fill_in);
               rsp_free_in  = brbs_pkg::count_type'(MAX_FILL - fill_in);
               rsp_valid_in = (state_in == brbs_pkg::ST_IDLE);
            end
         end
         brbs_pkg::ST_READ: begin
            rsp_rd_in    = mem_q_ff;
            rsp_valid_in = 1'b1;
            state_in     = brbs_pkg::ST_IDLE;
         end
         brbs_pkg::ST_FIND: begin
            if (mem_q_ff == key_ff) begin
               rsp_ok_in    = 1'b1;
               rsp_found_in = brbs_pkg::count_type'(idx_ff);
               rsp_valid_in = 1'b1;
               state_in     = brbs_pkg::ST_IDLE;
            end else if (idx_ff == fill_ff - 1'b1) begin
               rsp_valid_in = 1'b1;
               state_in     = brbs_pkg::ST_IDLE;
            end else begin
               idx_in  = idx_ff + 1'b1;
               scan_in = wrap_inc(scan_ff);
               rd_en   = 1'b1;
               rd_addr = wrap_inc(scan_ff);
            end
         end
         default: begin
            state_in = brbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brbs_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      scan_ff      <= scan_in;
      key_ff       <= key_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_rd_ff    <= rsp_rd_in;
      rsp_found_ff <= rsp_found_in;
      rsp_fill_ff  <= rsp_fill_in;
      rsp_free_ff  <= rsp_free_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   `BRBS_ASSERT_HOLDS(a_fill_matches_pointers, clock, reset,
      ({1'b0, fill_ff} == ptr_fill), "fill count disagrees with the pointers")
   `BRBS_ASSERT_HOLDS(a_fill_bounded, clock, reset,
      fill_ff <= MAX_FILL, "fill count exceeds the capacity")
   `BRBS_ASSERT_IMPLIES(a_busy_not_ready, clock, reset,
      state_ff != brbs_pkg::ST_IDLE, !req_tready, "request taken while busy")
   `BRBS_ASSERT_IMPLIES(a_scan_in_range, clock, reset,
      state_ff == brbs_pkg::ST_FIND, idx_ff < fill_ff, "search ran past the held bytes")
   `BRBS_ASSERT_NEXT(a_pop_reads, clock, reset,
      accept && req_op == brbs_pkg::OP_POP && fill_ff != '0,
      state_ff == brbs_pkg::ST_READ && !rsp_valid_ff, "pop did not wait for its read")

endmodule
